// ----- hw/rtl/asar_pkg.sv -----
// Shared constants, codes and types of the screen auto-rotation block.
// Used by asar_smul and accel_screen_auto_rotation; depends on nothing.
package asar_pkg;

   // accelerometer sample width (two's complement)
   localparam int ACCEL_WIDTH = 16;
   // width of the magnitude and cosine registers
   localparam int CFG_WIDTH = 15;
   // multiplier operand width, one bit retired per cycle while stepping
   localparam int MW = (ACCEL_WIDTH > CFG_WIDTH) ? ACCEL_WIDTH : CFG_WIDTH;
   // product width: cos^2 * (x^2 + y^2)
   localparam int PW = 2 * ACCEL_WIDTH + 2 * CFG_WIDTH;
   localparam int CNT_WIDTH = $clog2(MW);

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_MAGNITUDE    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STICKY_COSINE    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROTATION_LOCKED  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOCK_AXIS        = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NATURAL_PORTRAIT = 3'd4;

   // register reset values
   localparam logic [CFG_WIDTH-1:0] MIN_MAGNITUDE_RESET = 15'd1075;
   localparam logic [CFG_WIDTH-1:0] STICKY_COSINE_RESET = 15'd16384;

   // lock axis codes
   localparam logic [1:0] LOCK_FIXED     = 2'd0;
   localparam logic [1:0] LOCK_LANDSCAPE = 2'd1;
   localparam logic [1:0] LOCK_PORTRAIT  = 2'd2;

   // rotation codes
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // control of one serial multiplier
   typedef struct packed {
      logic load;
      logic step;
   } smul_ctl_type;

endpackage

// ----- hw/rtl/asar_smul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle while ctl.step is high, LSB first.
// Depends on asar_pkg for operand widths and the control struct.
module asar_smul (
   input  logic                      clock,
   input  asar_pkg::smul_ctl_type    ctl,
   input  logic [asar_pkg::PW-1:0]   mcand_in,
   input  logic [asar_pkg::MW-1:0]   mplier_in,
   output logic [asar_pkg::PW-1:0]   product
);
   import asar_pkg::*;

   logic [PW-1:0] mcand_ff;
   logic [MW-1:0] mplier_ff;
   logic [PW-1:0] acc_ff;

   // load operands, or retire one multiplier bit
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         mcand_ff  <= mcand_in;
         mplier_ff <= mplier_in;
         acc_ff    <= '0;
      end else if (ctl.step) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   assign product = acc_ff;

endmodule

// ----- hw/rtl/accel_screen_auto_rotation.sv -----
// Screen auto-rotation with sticky-angle hysteresis and lock policy.
// External sets and ignored samples go from idle straight to the finish state;
// a full sample runs three rounds of two bit-serial multipliers of MW steps
// each, then a decide state. The result loads in the finish state once the
// output is free; new requests stall until then.
// Reset (synchronous): rotation 0, registers to defaults, output empty.
module accel_screen_auto_rotation (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic signed [asar_pkg::ACCEL_WIDTH-1:0] req_accel_x,
   input  logic signed [asar_pkg::ACCEL_WIDTH-1:0] req_accel_y,
   input  logic                                  req_has_screen,
   input  logic                                  req_stable,
   input  logic [1:0]                            req_set_rotation,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_rotation,
   output logic                                  rsp_changed,
   // configuration write port
   input  logic                                  csr_write_en,
   input  logic [asar_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [asar_pkg::CFG_WIDTH-1:0]        csr_wdata
);
   import asar_pkg::*;

   localparam int W = ACCEL_WIDTH;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL1   = 3'd1;
   localparam logic [2:0] ST_LOAD2  = 3'd2;
   localparam logic [2:0] ST_MUL2   = 3'd3;
   localparam logic [2:0] ST_LOAD3  = 3'd4;
   localparam logic [2:0] ST_MUL3   = 3'd5;
   localparam logic [2:0] ST_DECIDE = 3'd6;
   localparam logic [2:0] ST_FIN    = 3'd7;

   // configuration
   logic [CFG_WIDTH-1:0] min_mag_ff;
   logic [CFG_WIDTH-1:0] cosine_ff;
   logic                 locked_ff;
   logic [1:0]           axis_ff;
   logic                 natural_portrait_ff;

   // control state
   logic [2:0]           state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic [1:0]           rot_ff;
   logic                 rsp_valid_ff;

   // working payload
   logic signed [W-1:0]  x_ff, y_ff;
   logic [1:0]           cand_ff;
   logic [1:0]           next_rot_ff;
   logic [2*W-1:0]       mag2_ff;
   logic [2*W-1:0]       dsq_ff;
   logic                 dpos_ff;
   logic [1:0]           rsp_rotation_ff;
   logic                 rsp_changed_ff;

   // multiplier hookup
   smul_ctl_type         ctl_a, ctl_b;
   logic [PW-1:0]        mcand_a, mcand_b, product_a, product_b;
   logic [MW-1:0]        mplier_a, mplier_b;

   logic                 req_accept, out_load, eligible;
   logic signed [W:0]    xe, ye, sum_xy, d_val;
   logic [W-1:0]         abs_x, abs_y;
   logic [1:0]           cand;
   logic [2*W-1:0]       mag2;
   logic [PW-1:0]        lhs, min2;
   logic                 mag_ok, sticky, natural_axis, allowed;
   logic [1:0]           decided;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_load   = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   // screen the sample against flags and lock policy
   assign eligible = (!locked_ff || axis_ff == LOCK_LANDSCAPE || axis_ff == LOCK_PORTRAIT) &&
                     req_has_screen && req_stable;

   // magnitudes and nearest quadrant of the incoming sample
   always_comb begin
      xe     = {req_accel_x[W-1], req_accel_x};
      ye     = {req_accel_y[W-1], req_accel_y};
      abs_x  = xe[W] ? W'(-xe) : W'(xe);
      abs_y  = ye[W] ? W'(-ye) : W'(ye);
      sum_xy = xe + ye;
      priority if (ye > xe && sum_xy >= 0) begin
         cand = ROT_0;
      end else if (xe >= ye && sum_xy > 0) begin
         cand = ROT_90;
      end else if (ye < xe && sum_xy <= 0) begin
         cand = ROT_180;
      end else begin
         cand = ROT_270;
      end
   end

   // down component for the current rotation
   always_comb begin
      unique case (rot_ff)
         ROT_0:   d_val = {y_ff[W-1], y_ff};
         ROT_90:  d_val = {x_ff[W-1], x_ff};
         ROT_180: d_val = -{y_ff[W-1], y_ff};
         ROT_270: d_val = -{x_ff[W-1], x_ff};
      endcase
   end

   assign mag2 = product_a[2*W-1:0] + product_b[2*W-1:0];

   // feed the two multipliers for each round
   always_comb begin
      ctl_a    = '0;
      ctl_b    = '0;
      mcand_a  = PW'(abs_x);
      mplier_a = MW'(abs_x);
      mcand_b  = PW'(abs_y);
      mplier_b = MW'(abs_y);
      unique case (state_ff)
         ST_IDLE: begin
            ctl_a.load = req_accept;
            ctl_b.load = req_accept;
         end
         ST_LOAD2: begin
            ctl_a.load = 1'b1;
            ctl_b.load = 1'b1;
            mcand_a    = PW'(d_val[W-1:0]);
            mplier_a   = MW'(d_val[W-1:0]);
            mcand_b    = PW'(mag2);
            mplier_b   = MW'(cosine_ff);
         end
         ST_LOAD3: begin
            ctl_a.load = 1'b1;
            ctl_b.load = 1'b1;
            mcand_a    = PW'(min_mag_ff);
            mplier_a   = MW'(min_mag_ff);
            mcand_b    = product_b;
            mplier_b   = MW'(cosine_ff);
         end
         ST_MUL1, ST_MUL2, ST_MUL3: begin
            ctl_a.step = 1'b1;
            ctl_b.step = 1'b1;
         end
         ST_DECIDE, ST_FIN: begin
         end
      endcase
   end

   asar_smul u_smul_a (
      .clock     (clock),
      .ctl       (ctl_a),
      .mcand_in  (mcand_a),
      .mplier_in (mplier_a),
      .product   (product_a)
   );

   asar_smul u_smul_b (
      .clock     (clock),
      .ctl       (ctl_b),
      .mcand_in  (mcand_b),
      .mplier_in (mplier_b),
      .product   (product_b)
   );

   // final tests: magnitude, sticky angle, lock policy
   always_comb begin
      min2         = product_a;
      lhs          = {dsq_ff, {(2*CFG_WIDTH){1'b0}}};
      mag_ok       = PW'(mag2_ff) >= min2;
      sticky       = dpos_ff && (lhs > product_b);
      natural_axis = (natural_portrait_ff && axis_ff == LOCK_PORTRAIT) ||
                     (!natural_portrait_ff && axis_ff == LOCK_LANDSCAPE);
      if (!locked_ff) begin
         allowed = 1'b1;
      end else if (axis_ff != LOCK_LANDSCAPE && axis_ff != LOCK_PORTRAIT) begin
         allowed = 1'b0;
      end else begin
         allowed = natural_axis ? !cand_ff[0] : cand_ff[0];
      end
      decided = (mag_ok && !sticky && allowed) ? cand_ff : rot_ff;
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_mode || !eligible) ? ST_FIN : ST_MUL1;
            end
         end
         ST_MUL1:   if (cnt_ff == '0) state_in = ST_LOAD2;
         ST_LOAD2:  state_in = ST_MUL2;
         ST_MUL2:   if (cnt_ff == '0) state_in = ST_LOAD3;
         ST_LOAD3:  state_in = ST_MUL3;
         ST_MUL3:   if (cnt_ff == '0) state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_FIN;
         ST_FIN:    if (out_load) state_in = ST_IDLE;
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         cnt_ff              <= '0;
         rot_ff              <= ROT_0;
         rsp_valid_ff        <= 1'b0;
         min_mag_ff          <= MIN_MAGNITUDE_RESET;
         cosine_ff           <= STICKY_COSINE_RESET;
         locked_ff           <= 1'b0;
         axis_ff             <= LOCK_FIXED;
         natural_portrait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // reload the bit counter for each multiply round
         if (ctl_a.load) begin
            cnt_ff <= CNT_WIDTH'(MW - 1);
         end else if (ctl_a.step) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (out_load) begin
            rot_ff       <= next_rot_ff;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_MIN_MAGNITUDE:    min_mag_ff          <= csr_wdata;
               CSR_STICKY_COSINE:    cosine_ff           <= csr_wdata;
               CSR_ROTATION_LOCKED:  locked_ff           <= csr_wdata[0];
               CSR_LOCK_AXIS:        axis_ff             <= csr_wdata[1:0];
               CSR_NATURAL_PORTRAIT: natural_portrait_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff        <= req_accel_x;
         y_ff        <= req_accel_y;
         cand_ff     <= cand;
         next_rot_ff <= req_mode ? req_set_rotation : rot_ff;
      end
      if (state_ff == ST_LOAD2) begin
         mag2_ff <= mag2;
         dpos_ff <= d_val > 0;
      end
      if (state_ff == ST_LOAD3) begin
         dsq_ff <= product_a[2*W-1:0];
      end
      if (state_ff == ST_DECIDE) begin
         next_rot_ff <= decided;
      end
      if (out_load) begin
         rsp_rotation_ff <= next_rot_ff;
         rsp_changed_ff  <= (next_rot_ff != rot_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rotation = rsp_rotation_ff;
   assign rsp_changed  = rsp_changed_ff;

   // reported rotation matches the stored rotation
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_rotation == rot_ff)
      else $error("reported rotation differs from stored rotation");

   // changed flag reflects a real rotation step
   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_changed == (rot_ff != $past(rot_ff)))
      else $error("changed flag inconsistent with rotation update");

   // rotation moves only when a result is loaded
   a_rotation_hold: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(rot_ff))
      else $error("rotation changed outside result load");

   // external set skips the arithmetic
   a_set_fast_path: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_mode |=> state_ff == ST_FIN)
      else $error("external set did not take the short path");

   // first multiply round ends after its last bit
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL1 && cnt_ff == '0 |=> state_ff == ST_LOAD2)
      else $error("multiply round overran");

endmodule
